// File: sv/dtf_pkg.sv
package dtf_pkg;

	localparam int DIV_W    = 64;
	localparam int REM_W    = 10;
	localparam int CHUNK_W  = 16;
	localparam int RECIP_W  = 28;
	localparam int RECIP_SH = 32;

	typedef struct packed {
		logic               load;
		logic               mul;
		logic               fix;
		logic [REM_W-1:0]   divisor;
		logic [RECIP_W-1:0] recip;
	} dtf_div_ctrl_t;

	// divisor for each split: ms, seconds, minutes, hours
	function automatic logic [REM_W-1:0] split_divisor(input logic [1:0] idx);
		logic [REM_W-1:0] d;
		case (idx)
			2'd0: d = REM_W'(1000);
			2'd1: d = REM_W'(60);
			2'd2: d = REM_W'(60);
			default: d = REM_W'(24);
		endcase
		return d;
	endfunction

	// floor(2^RECIP_SH / divisor), same order as split_divisor
	function automatic logic [RECIP_W-1:0] split_recip(input logic [1:0] idx);
		logic [RECIP_W-1:0] m;
		case (idx)
			2'd0: m = RECIP_W'((64'd1 << RECIP_SH) / 64'd1000);
			2'd1: m = RECIP_W'((64'd1 << RECIP_SH) / 64'd60);
			2'd2: m = RECIP_W'((64'd1 << RECIP_SH) / 64'd60);
			default: m = RECIP_W'((64'd1 << RECIP_SH) / 64'd24);
		endcase
		return m;
	endfunction

endpackage

// File: sv/dtf_div.sv
// Divider by a small constant, 16 dividend bits per step: a reciprocal multiply
// gives a quotient estimate at most one low, the next cycle corrects it.
module dtf_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dtf_pkg::dtf_div_ctrl_t       ctrl,
	input  logic [dtf_pkg::DIV_W-1:0]    load_val,
	output logic [dtf_pkg::DIV_W-1:0]    quot,
	output logic [dtf_pkg::REM_W-1:0]    rem
);

	localparam int X_W = dtf_pkg::REM_W + dtf_pkg::CHUNK_W;
	localparam int P_W = X_W + dtf_pkg::RECIP_W;

	logic [dtf_pkg::DIV_W-1:0]   dvd_q;
	logic [dtf_pkg::REM_W-1:0]   rem_q;
	logic [dtf_pkg::CHUNK_W-1:0] q0_q;
	logic [X_W-1:0]              x;
	logic [X_W-1:0]              qd;
	logic [X_W-1:0]              r0;
	logic [X_W:0]                diff;
	logic [P_W-1:0]              prod;
	logic                        ge;
	logic [dtf_pkg::CHUNK_W-1:0] q_fix;

	assign x     = {rem_q, dvd_q[dtf_pkg::DIV_W-1 -: dtf_pkg::CHUNK_W]};
	assign prod  = P_W'(x) * P_W'(ctrl.recip);
	assign qd    = X_W'(q0_q) * X_W'(ctrl.divisor);
	assign r0    = x - qd;
	assign diff  = {1'b0, r0} - (X_W+1)'(ctrl.divisor);
	assign ge    = !diff[X_W];
	assign q_fix = ge ? q0_q + dtf_pkg::CHUNK_W'(1) : q0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			dvd_q <= '0;
			q0_q  <= '0;
		end else if (ctrl.load) begin
			rem_q <= '0;
			dvd_q <= load_val;
		end else if (ctrl.mul) begin
			q0_q <= prod[dtf_pkg::RECIP_SH +: dtf_pkg::CHUNK_W];
		end else if (ctrl.fix) begin
			rem_q <= ge ? diff[dtf_pkg::REM_W-1:0] : r0[dtf_pkg::REM_W-1:0];
			dvd_q <= {dvd_q[dtf_pkg::DIV_W-dtf_pkg::CHUNK_W-1:0], q_fix};
		end
	end

	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

// File: sv/duration_text_formatter.sv
// Formats a signed millisecond duration as ASCII text, one character per output
// transfer with last on the final one. format_mode 0 gives [-][d.]HH:MM:SS[.fff],
// 1 gives ISO 8601 [-]P[nD][T[nH][nM][n[.f]S]] (zero is PT0S). One item at a time:
// in_stall stays high from acceptance until the final character is in the output
// register. The magnitude is split by a shared divider taking 16 bits per multiply/correct
// step (four divisions), days and milliseconds go to BCD by shift-and-add-3, then the
// text is built into a 32-entry buffer and sent one character per cycle while
// out_stall is low. The next item can be taken the cycle after the final character
// is loaded.
module duration_text_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] duration_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  char_code,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        format_mode
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_BCD_D = 3'd2;
	localparam logic [2:0] ST_BCD_M = 3'd3;
	localparam logic [2:0] ST_BUILD = 3'd4;
	localparam logic [2:0] ST_SEND  = 3'd5;

	localparam logic [4:0] SL_SIGN  = 5'd0;
	localparam logic [4:0] SL_P     = 5'd1;
	localparam logic [4:0] SL_ZT    = 5'd2;
	localparam logic [4:0] SL_Z0    = 5'd3;
	localparam logic [4:0] SL_ZS    = 5'd4;
	localparam logic [4:0] SL_DAYS  = 5'd5;
	localparam logic [4:0] SL_DSEP  = 5'd6;
	localparam logic [4:0] SL_T     = 5'd7;
	localparam logic [4:0] SL_HT    = 5'd8;
	localparam logic [4:0] SL_HU    = 5'd9;
	localparam logic [4:0] SL_HSEP  = 5'd10;
	localparam logic [4:0] SL_MT    = 5'd11;
	localparam logic [4:0] SL_MU    = 5'd12;
	localparam logic [4:0] SL_MSEP  = 5'd13;
	localparam logic [4:0] SL_ST    = 5'd14;
	localparam logic [4:0] SL_SU    = 5'd15;
	localparam logic [4:0] SL_DOT   = 5'd16;
	localparam logic [4:0] SL_F2    = 5'd17;
	localparam logic [4:0] SL_F1    = 5'd18;
	localparam logic [4:0] SL_F0    = 5'd19;
	localparam logic [4:0] SL_SSEP  = 5'd20;
	localparam logic [4:0] SL_END   = 5'd21;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_M     = 8'h4D;

	localparam logic [4:0] TEXT_MAX = 5'd29;

	// divider steps per split: four multiply/correct pairs, then capture
	localparam logic [3:0] DIV_LAST = 4'd8;

	logic [2:0]  state_q;
	logic        mode_q;
	logic        neg_q;
	logic [3:0]  cnt_q;
	logic [1:0]  idx_q;
	logic [9:0]  ms_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hr_q;
	logic [36:0] bin_q;
	logic [47:0] bcd_q;
	logic [5:0]  bcnt_q;
	logic [47:0] days_bcd_q;
	logic [11:0] ms_bcd_q;
	logic [4:0]  slot_q;
	logic [3:0]  di_q;
	logic        started_q;
	logic [4:0]  wptr_q;
	logic [4:0]  len_q;
	logic [4:0]  rptr_q;
	logic [7:0]  buf_q [32];
	logic        out_valid_q;
	logic [7:0]  char_q;
	logic        last_q;

	dtf_pkg::dtf_div_ctrl_t     div_ctrl;
	logic [dtf_pkg::DIV_W-1:0] div_load_val;
	logic [dtf_pkg::DIV_W-1:0] quot;
	logic [dtf_pkg::REM_W-1:0] rem;
	logic [63:0]               mag;
	logic                      in_acc;

	assign in_acc = in_valid && !in_stall;
	assign mag    = duration_ms[63] ? (~duration_ms + 64'd1) : duration_ms;

	always_comb begin
		div_ctrl.load    = in_acc || (state_q == ST_DIV && cnt_q == DIV_LAST);
		div_ctrl.mul     = (state_q == ST_DIV) && (cnt_q != DIV_LAST) && !cnt_q[0];
		div_ctrl.fix     = (state_q == ST_DIV) && (cnt_q != DIV_LAST) && cnt_q[0];
		div_ctrl.divisor = dtf_pkg::split_divisor(idx_q);
		div_ctrl.recip   = dtf_pkg::split_recip(idx_q);
		div_load_val     = (state_q == ST_IDLE) ? mag : quot;
	end

	dtf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.load_val (div_load_val),
		.quot     (quot),
		.rem      (rem)
	);

	// shift-and-add-3 step
	logic [47:0] adj;
	logic [47:0] bcd_n;
	always_comb begin
		for (int i = 0; i < 12; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
				: bcd_q[i*4 +: 4];
		end
		bcd_n = {adj[46:0], bin_q[36]};
	end

	function automatic logic [3:0] tens_of(input logic [5:0] v);
		logic [3:0] t;
		if (v >= 6'd50)      t = 4'd5;
		else if (v >= 6'd40) t = 4'd4;
		else if (v >= 6'd30) t = 4'd3;
		else if (v >= 6'd20) t = 4'd2;
		else if (v >= 6'd10) t = 4'd1;
		else                 t = 4'd0;
		return t;
	endfunction

	logic [3:0] hr_t, hr_u, min_t, min_u, sec_t, sec_u, day_d;
	logic       days_nz, hr_nz, min_nz, sec_or_ms, ms_nz, rest_nz, zero, iso;
	logic       wr_en;
	logic [7:0] wr_ch;

	always_comb begin
		hr_t  = tens_of({1'b0, hr_q});
		min_t = tens_of(min_q);
		sec_t = tens_of(sec_q);
		hr_u  = 4'(hr_q - {hr_t[1:0], 3'b0} - {1'b0, hr_t[2:0], 1'b0});
		min_u = 4'(min_q - {min_t[2:0], 3'b0} - {2'b0, min_t[2:0], 1'b0});
		sec_u = 4'(sec_q - {sec_t[2:0], 3'b0} - {2'b0, sec_t[2:0], 1'b0});
		day_d = days_bcd_q[di_q*4 +: 4];
		iso       = mode_q;
		days_nz   = days_bcd_q != '0;
		hr_nz     = hr_q != '0;
		min_nz    = min_q != '0;
		ms_nz     = ms_q != '0;
		sec_or_ms = (sec_q != '0) || ms_nz;
		rest_nz   = hr_nz || min_nz || sec_or_ms;
		zero      = !days_nz && !rest_nz;
		wr_en = 1'b0;
		wr_ch = CH_ZERO;
		case (slot_q)
			SL_SIGN: begin wr_en = neg_q; wr_ch = CH_MINUS; end
			SL_P:    begin wr_en = iso; wr_ch = CH_P; end
			SL_ZT:   begin wr_en = iso && zero; wr_ch = CH_T; end
			SL_Z0:   begin wr_en = iso && zero; wr_ch = CH_ZERO; end
			SL_ZS:   begin wr_en = iso && zero; wr_ch = CH_S; end
			SL_DAYS: begin
				wr_en = days_nz && (day_d != 4'd0 || started_q || di_q == 4'd0);
				wr_ch = CH_ZERO + {4'd0, day_d};
			end
			SL_DSEP: begin wr_en = days_nz; wr_ch = iso ? CH_D : CH_DOT; end
			SL_T:    begin wr_en = iso && rest_nz; wr_ch = CH_T; end
			SL_HT: begin
				wr_en = !iso || (hr_nz && hr_t != 4'd0);
				wr_ch = CH_ZERO + {4'd0, hr_t};
			end
			SL_HU:   begin wr_en = !iso || hr_nz; wr_ch = CH_ZERO + {4'd0, hr_u}; end
			SL_HSEP: begin wr_en = !iso || hr_nz; wr_ch = iso ? CH_H : CH_COLON; end
			SL_MT: begin
				wr_en = !iso || (min_nz && min_t != 4'd0);
				wr_ch = CH_ZERO + {4'd0, min_t};
			end
			SL_MU:   begin wr_en = !iso || min_nz; wr_ch = CH_ZERO + {4'd0, min_u}; end
			SL_MSEP: begin wr_en = !iso || min_nz; wr_ch = iso ? CH_M : CH_COLON; end
			SL_ST: begin
				wr_en = !iso || (sec_or_ms && sec_t != 4'd0);
				wr_ch = CH_ZERO + {4'd0, sec_t};
			end
			SL_SU:   begin wr_en = !iso || sec_or_ms; wr_ch = CH_ZERO + {4'd0, sec_u}; end
			SL_DOT:  begin wr_en = ms_nz; wr_ch = CH_DOT; end
			SL_F2:   begin wr_en = ms_nz; wr_ch = CH_ZERO + {4'd0, ms_bcd_q[11:8]}; end
			SL_F1: begin
				wr_en = ms_nz && (!iso || ms_bcd_q[7:0] != 8'd0);
				wr_ch = CH_ZERO + {4'd0, ms_bcd_q[7:4]};
			end
			SL_F0: begin
				wr_en = ms_nz && (!iso || ms_bcd_q[3:0] != 4'd0);
				wr_ch = CH_ZERO + {4'd0, ms_bcd_q[3:0]};
			end
			SL_SSEP: begin wr_en = iso && sec_or_ms; wr_ch = CH_S; end
			default: begin wr_en = 1'b0; wr_ch = CH_ZERO; end
		endcase
	end

	logic send_load;
	assign send_load = (state_q == ST_SEND) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			bcnt_q      <= '0;
			slot_q      <= SL_SIGN;
			di_q        <= '0;
			started_q   <= 1'b0;
			wptr_q      <= '0;
			len_q       <= '0;
			rptr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) mode_q <= format_mode;
			if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
						idx_q   <= '0;
					end
				end
				ST_DIV: begin
					if (cnt_q == DIV_LAST) begin
						cnt_q <= '0;
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							state_q <= ST_BCD_D;
							bcnt_q  <= '0;
						end
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_BCD_D: begin
					bcnt_q <= bcnt_q + 6'd1;
					if (bcnt_q == 6'd36) begin
						state_q <= ST_BCD_M;
						bcnt_q  <= '0;
					end
				end
				ST_BCD_M: begin
					bcnt_q <= bcnt_q + 6'd1;
					if (bcnt_q == 6'd9) begin
						state_q   <= ST_BUILD;
						slot_q    <= SL_SIGN;
						di_q      <= 4'd11;
						started_q <= 1'b0;
						wptr_q    <= '0;
					end
				end
				ST_BUILD: begin
					if (wr_en && wptr_q < TEXT_MAX) wptr_q <= wptr_q + 5'd1;
					if (slot_q == SL_DAYS && wr_en) started_q <= 1'b1;
					if (slot_q == SL_DAYS && di_q != 4'd0) begin
						di_q <= di_q - 4'd1;
					end else if (slot_q == SL_END) begin
						state_q <= ST_SEND;
						len_q   <= wptr_q;
						rptr_q  <= '0;
					end else begin
						slot_q <= slot_q + 5'd1;
					end
				end
				ST_SEND: begin
					if (send_load) begin
						out_valid_q <= 1'b1;
						rptr_q      <= rptr_q + 5'd1;
						if (rptr_q == len_q - 5'd1) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) neg_q <= duration_ms[63];
		if (state_q == ST_DIV && cnt_q == DIV_LAST) begin
			case (idx_q)
				2'd0: ms_q  <= rem;
				2'd1: sec_q <= rem[5:0];
				2'd2: min_q <= rem[5:0];
				default: begin
					hr_q  <= rem[4:0];
					bin_q <= quot[36:0];
					bcd_q <= '0;
				end
			endcase
		end
		if (state_q == ST_BCD_D) begin
			if (bcnt_q == 6'd36) begin
				days_bcd_q <= bcd_n;
				bcd_q      <= '0;
				bin_q      <= {ms_q, 27'd0};
			end else begin
				bcd_q <= bcd_n;
				bin_q <= {bin_q[35:0], 1'b0};
			end
		end
		if (state_q == ST_BCD_M) begin
			bcd_q <= bcd_n;
			bin_q <= {bin_q[35:0], 1'b0};
			if (bcnt_q == 6'd9) ms_bcd_q <= bcd_n[11:0];
		end
		if (state_q == ST_BUILD && wr_en && wptr_q < TEXT_MAX) buf_q[wptr_q] <= wr_ch;
		if (send_load) begin
			char_q <= buf_q[rptr_q];
			last_q <= rptr_q == len_q - 5'd1;
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_len_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND) |-> (len_q >= 5'd3))
		else $error("text shorter than three characters");
	a_rptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND) |-> (rptr_q < len_q))
		else $error("read pointer past text end");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_DIV && cnt_q == 4'd0 && idx_q == 2'd0))
		else $error("accepted item did not start division");
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= DIV_LAST))
		else $error("divider count overrun");
`endif

endmodule
